// ===== sv/fwsc_pkg.sv =====
// Fuzzy wheel speed controller: shared widths, codes, rule tables and types.
// No dependencies.
package fwsc_pkg;

  localparam int X_W    = 16;   // sonar range
  localparam int BP_W   = 13;   // breakpoint register
  localparam int G_W    = 15;   // grade, Q1.14 up to 1.0
  localparam int GNUM_W = 27;   // grade dividend: 13-bit difference shifted by 14
  localparam int NUM_W  = 27;   // weighted centroid sum
  localparam int DEN_W  = 19;   // weight sum over up to 27 rules
  localparam int PSUM_W = 18;   // weight sum over up to 9 rules
  localparam int SPD_W  = 8;
  localparam int NREG   = 8;
  localparam int IDX_W  = 3;

  localparam logic [G_W-1:0] ONE_Q14     = 15'd16384;
  localparam logic [G_W-1:0] GRADE_FLOOR = 15'd2;
  localparam logic [X_W-1:0] SHAPE_TOP   = 16'd5000;

  localparam logic [7:0] CENTROID_SLOW = 8'd20;
  localparam logic [7:0] CENTROID_MED  = 8'd150;
  localparam logic [7:0] CENTROID_FAST = 8'd220;

  // speed classes
  localparam logic [1:0] CLS_SLOW = 2'd0;
  localparam logic [1:0] CLS_MED  = 2'd1;
  localparam logic [1:0] CLS_FAST = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FOLLOW_LOW_END  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FOLLOW_LOW_ZERO = 3'd1;
  localparam logic [IDX_W-1:0] REG_FOLLOW_MID_END  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FOLLOW_MID_ZERO = 3'd3;
  localparam logic [IDX_W-1:0] REG_AVOID_LOW_END   = 3'd4;
  localparam logic [IDX_W-1:0] REG_AVOID_LOW_ZERO  = 3'd5;
  localparam logic [IDX_W-1:0] REG_AVOID_MID_END   = 3'd6;
  localparam logic [IDX_W-1:0] REG_AVOID_MID_ZERO  = 3'd7;

  localparam logic [BP_W-1:0] REG_RESET [NREG] = '{
    13'd600, 13'd700, 13'd750, 13'd1000, 13'd700, 13'd900, 13'd1000, 13'd1250
  };

  // follower rules, index g1*3+g2
  localparam logic [1:0] FOLLOW_LEFT [9] = '{
    CLS_SLOW, CLS_SLOW, CLS_SLOW,
    CLS_SLOW, CLS_MED,  CLS_SLOW,
    CLS_FAST, CLS_FAST, CLS_FAST
  };
  localparam logic [1:0] FOLLOW_RIGHT [9] = '{
    CLS_FAST, CLS_FAST, CLS_FAST,
    CLS_FAST, CLS_MED,  CLS_MED,
    CLS_SLOW, CLS_SLOW, CLS_SLOW
  };

  // avoider rules, index g1*9+g2*3+g3
  localparam logic [1:0] AVOID_LEFT [27] = '{
    CLS_SLOW, CLS_SLOW, CLS_SLOW, CLS_FAST, CLS_FAST, CLS_FAST, CLS_SLOW, CLS_MED,  CLS_FAST,
    CLS_SLOW, CLS_MED,  CLS_FAST, CLS_SLOW, CLS_MED,  CLS_FAST, CLS_SLOW, CLS_MED,  CLS_FAST,
    CLS_SLOW, CLS_SLOW, CLS_SLOW, CLS_SLOW, CLS_SLOW, CLS_SLOW, CLS_SLOW, CLS_MED,  CLS_MED
  };
  localparam logic [1:0] AVOID_RIGHT [27] = '{
    CLS_FAST, CLS_FAST, CLS_FAST, CLS_SLOW, CLS_SLOW, CLS_SLOW, CLS_FAST, CLS_SLOW, CLS_SLOW,
    CLS_FAST, CLS_FAST, CLS_SLOW, CLS_FAST, CLS_FAST, CLS_SLOW, CLS_FAST, CLS_FAST, CLS_SLOW,
    CLS_FAST, CLS_FAST, CLS_FAST, CLS_FAST, CLS_FAST, CLS_FAST, CLS_FAST, CLS_FAST, CLS_MED
  };

  typedef logic [3:0][BP_W-1:0] bp4_t;    // le, lz, me, mz from bit 0 up
  typedef logic [2:0][G_W-1:0]  grade3_t; // low, medium, high

  typedef struct packed {
    logic [NUM_W-1:0] fl_num;
    logic [NUM_W-1:0] fr_num;
    logic [DEN_W-1:0] f_den;
    logic [NUM_W-1:0] al_num;
    logic [NUM_W-1:0] ar_num;
    logic [DEN_W-1:0] a_den;
  } sums_t;

  typedef struct packed {
    logic [SPD_W-1:0] avoid_right;
    logic [SPD_W-1:0] avoid_left;
    logic [SPD_W-1:0] follow_right;
    logic [SPD_W-1:0] follow_left;
  } speeds_t;

endpackage

// ===== sv/fuzzy_wheel_speed_controller.sv =====
// Fuzzy wheel speed controller: edge follower and obstacle avoider on six sonar ranges.
// Accepts one input word per cycle while the skid is empty.
// Depth is set by the two divider chains: 15 stages for the trapezoid edges, 8 for averages.
// A two-entry output (register plus skid) keeps the input open while one result waits.
// Reset clears all valid bits and loads the breakpoint registers with their defaults.
module fuzzy_wheel_speed_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // range_two, three, four, five, six, seven (16b each)
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // follow_left, follow_right, avoid_left, avoid_right
);
  localparam int XW = fwsc_pkg::X_W;

  logic [fwsc_pkg::BP_W-1:0] cfg_q [fwsc_pkg::NREG];
  fwsc_pkg::bp4_t bp_follow, bp_avoid;

  logic          en;           // whole pipeline advances together
  logic          in_fire;
  logic [XW-1:0] rng [6];
  logic [XW-1:0] min456, min34;
  logic [XW-1:0] x_q [5];
  logic          v0_q;

  logic [4:0]        gvld;
  fwsc_pkg::grade3_t g [5];
  logic              rvld;
  fwsc_pkg::sums_t   sums;
  logic [3:0]        dvld;
  fwsc_pkg::speeds_t spd;

  logic              out_vld_q, skid_vld_q;
  fwsc_pkg::speeds_t out_q, skid_q;
  logic              take, arrive;

  // breakpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fwsc_pkg::NREG; i++) cfg_q[i] <= fwsc_pkg::REG_RESET[i];
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign bp_follow[0] = cfg_q[fwsc_pkg::REG_FOLLOW_LOW_END];
  assign bp_follow[1] = cfg_q[fwsc_pkg::REG_FOLLOW_LOW_ZERO];
  assign bp_follow[2] = cfg_q[fwsc_pkg::REG_FOLLOW_MID_END];
  assign bp_follow[3] = cfg_q[fwsc_pkg::REG_FOLLOW_MID_ZERO];
  assign bp_avoid[0]  = cfg_q[fwsc_pkg::REG_AVOID_LOW_END];
  assign bp_avoid[1]  = cfg_q[fwsc_pkg::REG_AVOID_LOW_ZERO];
  assign bp_avoid[2]  = cfg_q[fwsc_pkg::REG_AVOID_MID_END];
  assign bp_avoid[3]  = cfg_q[fwsc_pkg::REG_AVOID_MID_ZERO];

  // stall only when the skid holds a word
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // input stage: sensor minima
  always_comb begin
    for (int i = 0; i < 6; i++) rng[i] = s_axis_tdata[i*XW +: XW];
    min456 = (rng[2] < rng[3]) ? rng[2] : rng[3];
    min456 = (min456 < rng[4]) ? min456 : rng[4];
    min34  = (rng[1] < rng[2]) ? rng[1] : rng[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= min456;
      x_q[1] <= rng[5];
      x_q[2] <= rng[0];
      x_q[3] <= min34;
      x_q[4] <= rng[3];
    end
  end

  // grading: first two follower inputs, last three avoider inputs
  for (genvar i = 0; i < 5; i++) begin : g_grade
    fwsc_grade u_grade (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (v0_q),
      .x_i    (x_q[i]),
      .bp_i   ((i < 2) ? bp_follow : bp_avoid),
      .vld_o  (gvld[i]),
      .g_o    (g[i])
    );
  end

  fwsc_rules u_rules (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (gvld[0]),
    .g_fa_i (g[0]),
    .g_fb_i (g[1]),
    .g_aa_i (g[2]),
    .g_ab_i (g[3]),
    .g_ac_i (g[4]),
    .vld_o  (rvld),
    .sums_o (sums)
  );

  // weighted averages; quotient never exceeds the fast centroid
  fwsc_div #(.NUM_W(fwsc_pkg::NUM_W), .DEN_W(fwsc_pkg::DEN_W), .Q_W(fwsc_pkg::SPD_W)) u_div_fl (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(rvld),
    .num_i(sums.fl_num), .den_i(sums.f_den), .vld_o(dvld[0]), .q_o(spd.follow_left)
  );
  fwsc_div #(.NUM_W(fwsc_pkg::NUM_W), .DEN_W(fwsc_pkg::DEN_W), .Q_W(fwsc_pkg::SPD_W)) u_div_fr (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(rvld),
    .num_i(sums.fr_num), .den_i(sums.f_den), .vld_o(dvld[1]), .q_o(spd.follow_right)
  );
  fwsc_div #(.NUM_W(fwsc_pkg::NUM_W), .DEN_W(fwsc_pkg::DEN_W), .Q_W(fwsc_pkg::SPD_W)) u_div_al (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(rvld),
    .num_i(sums.al_num), .den_i(sums.a_den), .vld_o(dvld[2]), .q_o(spd.avoid_left)
  );
  fwsc_div #(.NUM_W(fwsc_pkg::NUM_W), .DEN_W(fwsc_pkg::DEN_W), .Q_W(fwsc_pkg::SPD_W)) u_div_ar (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(rvld),
    .num_i(sums.ar_num), .den_i(sums.a_den), .vld_o(dvld[3]), .q_o(spd.avoid_right)
  );

  // output register plus skid; a word leaves the pipe only on an advancing edge
  assign take   = out_vld_q && m_axis_tready;
  assign arrive = dvld[0] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (arrive) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) out_q <= skid_q;
    end else if (arrive) begin
      if (out_vld_q && !take) skid_q <= spd;
      else out_q <= spd;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // skid is only ever used behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a word while output is empty");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  // a stalled pipeline never loses the word waiting at its end
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !take && dvld[0]) |=> dvld[0])
    else $error("pipeline word dropped during stall");

endmodule

// ===== sv/fwsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit Q_W bits. Uses no package.
module fwsc_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 13,
  parameter int Q_W   = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             vld_o,
  output logic [Q_W-1:0]   q_o
);
  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic             vld_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic             vld_in;
    logic [W-1:0]     shifted;
    logic             ge;
    logic [NUM_W-1:0] rem_d;
    logic [Q_W-1:0]   quo_d;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    always_comb begin
      shifted  = W'(den_in) << B;
      ge       = W'(rem_in) >= shifted;
      rem_d    = ge ? NUM_W'(W'(rem_in) - shifted) : rem_in;
      quo_d    = quo_in;
      quo_d[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign vld_o = vld_q[Q_W-1];
  assign q_o   = quo_q[Q_W-1];

endmodule

// ===== sv/fwsc_grade.sv =====
// Trapezoid grading of one range into low, medium, high Q1.14 grades.
// Depends on fwsc_pkg and fwsc_div.
module fwsc_grade (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [fwsc_pkg::X_W-1:0]    x_i,
  input  fwsc_pkg::bp4_t              bp_i,
  output logic                        vld_o,
  output fwsc_pkg::grade3_t           g_o
);
  typedef struct packed {
    logic [fwsc_pkg::GNUM_W-1:0] num;
    logic [fwsc_pkg::BP_W-1:0]   den;
  } div_in_t;

  // plateau gives 1/1, outside gives 0/1 (floored later)
  function automatic div_in_t trap(input logic [15:0] x, input logic [15:0] x1,
                                   input logic [15:0] x2, input logic [15:0] x3,
                                   input logic [15:0] x4);
    div_in_t r;
    if (x > x1 && x < x2) begin
      r.num = {13'(x - x1), 14'd0};
      r.den = 13'(x2 - x1);
    end else if (x >= x2 && x <= x3) begin
      r.num = 27'(fwsc_pkg::ONE_Q14);
      r.den = 13'd1;
    end else if (x > x3 && x < x4) begin
      r.num = {13'(x4 - x), 14'd0};
      r.den = 13'(x4 - x3);
    end else begin
      r.num = '0;
      r.den = 13'd1;
    end
    return r;
  endfunction

  logic [15:0] le, lz, me, mz;
  div_in_t     sh_d [3];
  div_in_t     sh_q [3];
  logic        vld1_q;
  logic [2:0]  dvld;
  logic [2:0][fwsc_pkg::G_W-1:0] quo;
  fwsc_pkg::grade3_t g_q;
  logic        vld2_q;

  assign le = 16'(bp_i[0]);
  assign lz = 16'(bp_i[1]);
  assign me = 16'(bp_i[2]);
  assign mz = 16'(bp_i[3]);

  always_comb begin
    sh_d[0] = trap(x_i, 16'd0, 16'd0, le, lz);
    sh_d[1] = trap(x_i, le, lz, me, mz);
    sh_d[2] = trap(x_i, me, mz, fwsc_pkg::SHAPE_TOP, fwsc_pkg::SHAPE_TOP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= dvld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sh_q[i] <= sh_d[i];
        g_q[i]  <= (quo[i] < fwsc_pkg::GRADE_FLOOR) ? fwsc_pkg::GRADE_FLOOR : quo[i];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    fwsc_div #(
      .NUM_W (fwsc_pkg::GNUM_W),
      .DEN_W (fwsc_pkg::BP_W),
      .Q_W   (fwsc_pkg::G_W)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (vld1_q),
      .num_i  (sh_q[i].num),
      .den_i  (sh_q[i].den),
      .vld_o  (dvld[i]),
      .q_o    (quo[i])
    );
  end

  assign vld_o = vld2_q;
  assign g_o   = g_q;

endmodule

// ===== sv/fwsc_rules.sv =====
// Rule firing (min) and weighted centroid sums for both controllers.
// Depends on fwsc_pkg.
module fwsc_rules (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  fwsc_pkg::grade3_t g_fa_i,   // min of ranges four to six
  input  fwsc_pkg::grade3_t g_fb_i,   // range seven
  input  fwsc_pkg::grade3_t g_aa_i,   // range two
  input  fwsc_pkg::grade3_t g_ab_i,   // min of ranges three and four
  input  fwsc_pkg::grade3_t g_ac_i,   // range five
  output logic              vld_o,
  output fwsc_pkg::sums_t   sums_o
);
  localparam int PW = fwsc_pkg::PSUM_W;
  localparam int DW = fwsc_pkg::DEN_W;
  localparam int NW = fwsc_pkg::NUM_W;

  logic [fwsc_pkg::G_W-1:0] wf_d [9];
  logic [fwsc_pkg::G_W-1:0] wf_q [9];
  logic [fwsc_pkg::G_W-1:0] wa_d [27];
  logic [fwsc_pkg::G_W-1:0] wa_q [27];
  logic [PW-1:0] sfl_d [3], sfr_d [3], sfl_q [3], sfr_q [3];
  logic [PW-1:0] sal_d [3][3], sar_d [3][3], sal_q [3][3], sar_q [3][3];
  fwsc_pkg::sums_t sums_d, sums_q;
  logic vw_q, vs_q, vo_q;

  function automatic logic [NW-1:0] wsum(input logic [DW-1:0] s0, input logic [DW-1:0] s1,
                                         input logic [DW-1:0] s2);
    return NW'(s0) * NW'(fwsc_pkg::CENTROID_SLOW) + NW'(s1) * NW'(fwsc_pkg::CENTROID_MED)
         + NW'(s2) * NW'(fwsc_pkg::CENTROID_FAST);
  endfunction

  // stage 1: rule strengths
  always_comb begin
    logic [fwsc_pkg::G_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wf_d[i*3+j] = (g_fa_i[i] < g_fb_i[j]) ? g_fa_i[i] : g_fb_i[j];
        m = (g_aa_i[i] < g_ab_i[j]) ? g_aa_i[i] : g_ab_i[j];
        for (int k = 0; k < 3; k++) begin
          wa_d[i*9+j*3+k] = (m < g_ac_i[k]) ? m : g_ac_i[k];
        end
      end
    end
  end

  // stage 2: per-class weight sums, avoider split in three groups of nine
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sfl_d[c] = '0;
      sfr_d[c] = '0;
      for (int r = 0; r < 9; r++) begin
        if (fwsc_pkg::FOLLOW_LEFT[r] == 2'(c))  sfl_d[c] = sfl_d[c] + PW'(wf_q[r]);
        if (fwsc_pkg::FOLLOW_RIGHT[r] == 2'(c)) sfr_d[c] = sfr_d[c] + PW'(wf_q[r]);
      end
      for (int g = 0; g < 3; g++) begin
        sal_d[g][c] = '0;
        sar_d[g][c] = '0;
        for (int r = 0; r < 9; r++) begin
          if (fwsc_pkg::AVOID_LEFT[g*9+r] == 2'(c))
            sal_d[g][c] = sal_d[g][c] + PW'(wa_q[g*9+r]);
          if (fwsc_pkg::AVOID_RIGHT[g*9+r] == 2'(c))
            sar_d[g][c] = sar_d[g][c] + PW'(wa_q[g*9+r]);
        end
      end
    end
  end

  // stage 3: centroid products
  always_comb begin
    logic [DW-1:0] tl [3];
    logic [DW-1:0] tr [3];
    for (int c = 0; c < 3; c++) begin
      tl[c] = DW'(sal_q[0][c]) + DW'(sal_q[1][c]) + DW'(sal_q[2][c]);
      tr[c] = DW'(sar_q[0][c]) + DW'(sar_q[1][c]) + DW'(sar_q[2][c]);
    end
    sums_d.fl_num = wsum(DW'(sfl_q[0]), DW'(sfl_q[1]), DW'(sfl_q[2]));
    sums_d.fr_num = wsum(DW'(sfr_q[0]), DW'(sfr_q[1]), DW'(sfr_q[2]));
    sums_d.f_den  = DW'(sfl_q[0]) + DW'(sfl_q[1]) + DW'(sfl_q[2]);
    sums_d.al_num = wsum(tl[0], tl[1], tl[2]);
    sums_d.ar_num = wsum(tr[0], tr[1], tr[2]);
    sums_d.a_den  = tl[0] + tl[1] + tl[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= 1'b0;
      vs_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vw_q <= vld_i;
      vs_q <= vw_q;
      vo_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wf_q   <= wf_d;
      wa_q   <= wa_d;
      sfl_q  <= sfl_d;
      sfr_q  <= sfr_d;
      sal_q  <= sal_d;
      sar_q  <= sar_d;
      sums_q <= sums_d;
    end
  end

  assign vld_o  = vo_q;
  assign sums_o = sums_q;

endmodule

// ===== sim/fwsc_checker.sv =====
// Checker for the fuzzy wheel speed controller: watches both streams, predicts speeds.
// Depends on fwsc_pkg and the config port that tb drives.
module fwsc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [95:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [fwsc_pkg::BP_W-1:0] bp [fwsc_pkg::NREG];
  fwsc_pkg::speeds_t speed_q[$];

  assign pending_o = speed_q.size();

  function automatic longint unsigned centroid(logic [1:0] c);
    case (c)
      fwsc_pkg::CLS_SLOW: return 64'(fwsc_pkg::CENTROID_SLOW);
      fwsc_pkg::CLS_MED:  return 64'(fwsc_pkg::CENTROID_MED);
      default:            return 64'(fwsc_pkg::CENTROID_FAST);
    endcase
  endfunction

  function automatic longint unsigned trap(longint unsigned x, longint unsigned x1,
      longint unsigned x2, longint unsigned x3, longint unsigned x4);
    longint unsigned g;
    if (x > x1 && x < x2) g = ((x - x1) << 14) / (x2 - x1);
    else if (x >= x2 && x <= x3) g = 64'(fwsc_pkg::ONE_Q14);
    else if (x > x3 && x < x4) g = ((x4 - x) << 14) / (x4 - x3);
    else g = 64'(fwsc_pkg::GRADE_FLOOR);
    if (g < 64'(fwsc_pkg::GRADE_FLOOR)) g = 64'(fwsc_pkg::GRADE_FLOOR);
    return g;
  endfunction

  function automatic void grades(longint unsigned x, int base, output longint unsigned g[3]);
    g[0] = trap(x, 0, 0, 64'(bp[base]), 64'(bp[base+1]));
    g[1] = trap(x, 64'(bp[base]), 64'(bp[base+1]), 64'(bp[base+2]), 64'(bp[base+3]));
    g[2] = trap(x, 64'(bp[base+2]), 64'(bp[base+3]), 64'(fwsc_pkg::SHAPE_TOP),
                64'(fwsc_pkg::SHAPE_TOP));
  endfunction

  function automatic longint unsigned min2(longint unsigned a, longint unsigned b);
    return a < b ? a : b;
  endfunction

  function automatic fwsc_pkg::speeds_t wheel_speeds(logic [95:0] d);
    longint unsigned r[6];
    longint unsigned ga[3], gb[3], gc[3];
    longint unsigned nl, nr, den, w;
    fwsc_pkg::speeds_t s;
    for (int i = 0; i < 6; i++) r[i] = 64'(d[16*i +: 16]);
    grades(min2(min2(r[2], r[3]), r[4]), 0, ga);
    grades(r[5], 0, gb);
    nl = 0; nr = 0; den = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        w = min2(ga[i], gb[j]);
        nl += w * centroid(fwsc_pkg::FOLLOW_LEFT[i*3+j]);
        nr += w * centroid(fwsc_pkg::FOLLOW_RIGHT[i*3+j]);
        den += w;
      end
    s.follow_left  = 8'(nl / den);
    s.follow_right = 8'(nr / den);
    grades(r[0], 4, ga);
    grades(min2(r[1], r[2]), 4, gb);
    grades(r[3], 4, gc);
    nl = 0; nr = 0; den = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) begin
          w = min2(min2(ga[i], gb[j]), gc[k]);
          nl += w * centroid(fwsc_pkg::AVOID_LEFT[i*9+j*3+k]);
          nr += w * centroid(fwsc_pkg::AVOID_RIGHT[i*9+j*3+k]);
          den += w;
        end
    s.avoid_left  = 8'(nl / den);
    s.avoid_right = 8'(nr / den);
    return s;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fwsc_pkg::speeds_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < fwsc_pkg::NREG; i++) bp[i] = fwsc_pkg::REG_RESET[i];
      speed_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) speed_q.push_back(wheel_speeds(in_data_i));
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (speed_q.size() == 0) report("unexpected word", int'(got), 0);
        else begin
          want = speed_q.pop_front();
          if (got.follow_left != want.follow_left)
            report("follow_left", int'(got.follow_left), int'(want.follow_left));
          if (got.follow_right != want.follow_right)
            report("follow_right", int'(got.follow_right), int'(want.follow_right));
          if (got.avoid_left != want.avoid_left)
            report("avoid_left", int'(got.avoid_left), int'(want.avoid_left));
          if (got.avoid_right != want.avoid_right)
            report("avoid_right", int'(got.avoid_right), int'(want.avoid_right));
        end
      end
      if (cfg_we_i) bp[cfg_idx_i] = cfg_data_i;
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the fuzzy wheel speed controller: stimulus, config phases, verdict.
// Depends on fwsc_pkg, fuzzy_wheel_speed_controller and fwsc_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 29;   // drain wait after the checker queue empties
  localparam int WATCHDOG = 2000; // cycles with no word moving

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_count, pending, quiet;
  bit          calm;      // no idling in the closing stretch
  bit          done;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fuzzy_wheel_speed_controller dut (.*);

  fwsc_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall bursts until the calm stretch
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on words moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
      quiet <= 0;
    else if (rst_ni) begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // range near a breakpoint, across the shapes, near the shape top, the maximum, or anywhere in 16 bits
  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 1400));
      1: return 16'($urandom_range(0, 5200));
      2: return 16'($urandom());
      default: return $urandom_range(0, 2) == 0 ? 16'hffff : 16'($urandom_range(4990, 5010));
    endcase
  endfunction

  task automatic send_word(logic [95:0] d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_bps(logic [12:0] v[8]);
    for (int i = 0; i < fwsc_pkg::NREG; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[2:0];
      cfg_data_i <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [95:0] d;
    logic [12:0] bps[8];
    calm = 1'b0;
    done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, breakpoints of the reset shapes, the shape top, a mixed word, alternating bit patterns
    send_word('0);
    send_word({96{1'b1}});
    for (int i = 0; i < fwsc_pkg::NREG; i++) begin
      send_word({6{3'b0, fwsc_pkg::REG_RESET[i]}});
      send_word({6{3'b0, fwsc_pkg::REG_RESET[i] + 13'd1}});
    end
    send_word({6{16'd5000}});
    send_word({6{16'd5001}});
    send_word({16'd300, 16'd2000, 16'd800, 16'd650, 16'd1100, 16'd900});
    send_word({16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
    send_word({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});

    // phases: reset values, zeros, max, out of order, doubled reset values, random
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      for (int i = 0; i < fwsc_pkg::NREG; i++)
        case (ph)
          0: bps[i] = fwsc_pkg::REG_RESET[i];
          1: bps[i] = 13'd0;
          2: bps[i] = 13'h1fff;
          3: bps[i] = 13'd5000 - 13'(i * 600);
          4: bps[i] = 13'(fwsc_pkg::REG_RESET[i] * 2);
          default: bps[i] = 13'($urandom_range(0, 8191));
        endcase
      write_bps(bps);
      repeat (ph < 5 ? 150 : 730) begin
        if (ph == 5) calm = 1'b1;
        for (int k = 0; k < 6; k++) d[16*k +: 16] = pick_range();
        send_word(d);
      end
    end

    drain();
    done = 1'b1;
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// ===== fuzzy_wheel_speed_controller.f =====
sv/fwsc_pkg.sv
sv/fwsc_div.sv
sv/fwsc_grade.sv
sv/fwsc_rules.sv
sv/fuzzy_wheel_speed_controller.sv
sim/fwsc_checker.sv
sim/tb.sv
